@@ hdl/sst_pkg.sv @@
// Shared types and constants for the Solovay-Strassen prime test block.
// No dependencies.
`timescale 1ns / 1ps
package sst_pkg;
	localparam int WORD_BITS = 32;
	typedef logic [WORD_BITS-1:0] word_t;
	typedef enum logic [1:0] {
		VERDICT_COMPOSITE = 2'd0,
		VERDICT_PRIME     = 2'd1,
		VERDICT_INVALID   = 2'd2
	} verdict_t;
	// divider request/response between sequencer and shared remainder unit
	typedef struct packed {
		logic  start;
		word_t dividend;
		word_t divisor;
	} div_req_t;
	typedef struct packed {
		logic  done;
		word_t remainder;
	} div_rsp_t;
endpackage

@@ hdl/sst_rem.sv @@
// Restoring remainder unit, one quotient bit per cycle.
// Depends on sst_pkg.
`timescale 1ns / 1ps
module sst_rem (
	input  logic              clk,
	input  logic              arst_n,
	input  sst_pkg::div_req_t req,
	output sst_pkg::div_rsp_t rsp
);
	import sst_pkg::*;
	localparam int CW = $clog2(WORD_BITS + 1);
	logic [WORD_BITS:0] rem_q;
	word_t              dvd_q;
	word_t              dvs_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [WORD_BITS:0] trial;
	logic [WORD_BITS:0] shifted;

	// shift in next dividend bit and try the subtract
	always_comb begin
		shifted = {rem_q[WORD_BITS-1:0], dvd_q[WORD_BITS-1]};
		trial   = shifted - {1'b0, dvs_q};
	end

	// advance one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WORD_BITS);
				rem_q  <= '0;
				dvd_q  <= req.dividend;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= trial[WORD_BITS] ? shifted : trial;
				dvd_q <= {dvd_q[WORD_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q[WORD_BITS-1:0];
endmodule

@@ hdl/solovay_strassen_prime_test.sv @@
// Solovay-Strassen prime test top level: sequencer, shared modular adder.
// Depends on sst_pkg and sst_rem.
//
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/in_stall   | candidate, witness_base
// out     | output    | out_valid/out_stall | verdict, euler_power, jacobi_symbol
//
// One item at a time: b mod n on the remainder unit, then per exponent bit up to
// two shift-and-add modular products (a doubling per multiplier bit, and an add
// where the bit is set); then the Jacobi loop with a remainder step for each swap
// and a halving for each even top. All products use the single modular adder and
// all reductions the bit-serial remainder unit. An invalid candidate gives its
// result in the cycle after its transfer.
// Reset clears the sequencer; the result register holds while out_stall is high
// and the next item is taken only once the result is transferred.
`timescale 1ns / 1ps
module solovay_strassen_prime_test (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sst_pkg::word_t      candidate,
	input  sst_pkg::word_t      witness_base,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          verdict,
	output sst_pkg::word_t      euler_power,
	output logic signed [1:0]   jacobi_symbol
);
	import sst_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_BMOD, ST_EXP, ST_MUL, ST_JEVEN, ST_JSWAP, ST_JMOD, ST_DONE
	} state_t;

	state_t    state_q;
	word_t     n_q, acc_q, sq_q, exp_q, top_q, bot_q;
	word_t     mx_q, my_q, macc_q;
	logic      mul_sq_q;     // current product: 0 acc*sq, 1 sq*sq
	logic      sign_q;
	logic      out_valid_q;
	logic [1:0] verdict_q;
	word_t     power_q;
	logic [1:0] sym_q;
	div_req_t  dreq;
	div_rsp_t  drsp;
	word_t     add_x, add_y, add_sum;
	logic [WORD_BITS:0] add_wide;

	sst_rem u_rem (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// shared modular adder: x + y mod n, inputs below n
	always_comb begin
		add_x = mx_q;
		add_y = mx_q;
		if (my_q[0]) begin
			add_x = macc_q;
		end
		add_wide = {1'b0, add_x} + {1'b0, add_y};
		add_sum  = (add_wide >= {1'b0, n_q}) ? WORD_BITS'(add_wide - {1'b0, n_q})
			: add_wide[WORD_BITS-1:0];
	end

	// remainder requests
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = witness_base;
		dreq.divisor  = candidate;
		if (state_q == ST_IDLE && in_valid && !out_valid_q && !(candidate < WORD_BITS'(3)
				|| !candidate[0])) begin
			dreq.start = 1'b1;
		end else if (state_q == ST_JSWAP) begin
			dreq.start    = 1'b1;
			dreq.dividend = bot_q;
			dreq.divisor  = top_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE) || out_valid_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			acc_q       <= WORD_BITS'(1);
			sq_q        <= '0;
			exp_q       <= '0;
			top_q       <= '0;
			bot_q       <= '0;
			mx_q        <= '0;
			my_q        <= '0;
			macc_q      <= '0;
			mul_sq_q    <= 1'b0;
			sign_q      <= 1'b0;
			verdict_q   <= VERDICT_COMPOSITE;
			power_q     <= '0;
			sym_q       <= 2'b00;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !out_valid_q) begin
						n_q <= candidate;
						if (candidate < WORD_BITS'(3) || !candidate[0]) begin
							verdict_q   <= VERDICT_INVALID;
							power_q     <= '0;
							sym_q       <= 2'b00;
							out_valid_q <= 1'b1;
						end else begin
							exp_q   <= (candidate - 1'b1) >> 1;
							acc_q   <= WORD_BITS'(1);
							state_q <= ST_BMOD;
						end
					end
				end
				ST_BMOD: begin
					if (drsp.done) begin
						sq_q    <= drsp.remainder;
						top_q   <= drsp.remainder;
						state_q <= ST_EXP;
					end
				end
				ST_EXP: begin
					// pick next product or finish exponentiation
					if (exp_q == '0) begin
						bot_q   <= n_q;
						sign_q  <= 1'b0;
						state_q <= ST_JEVEN;
					end else begin
						macc_q  <= '0;
						mx_q    <= sq_q;
						if (exp_q[0]) begin
							my_q     <= acc_q;
							mul_sq_q <= 1'b0;
						end else begin
							my_q     <= sq_q;
							mul_sq_q <= 1'b1;
						end
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// one shift-and-add step per cycle
					if (my_q == '0) begin
						if (!mul_sq_q) begin
							acc_q    <= macc_q;
							macc_q   <= '0;
							mx_q     <= sq_q;
							my_q     <= sq_q;
							mul_sq_q <= 1'b1;
						end else begin
							sq_q    <= macc_q;
							exp_q   <= exp_q >> 1;
							state_q <= ST_EXP;
						end
					end else if (my_q[0]) begin
						macc_q <= add_sum;
						my_q   <= my_q & ~WORD_BITS'(1);
					end else begin
						mx_q <= add_sum;
						my_q <= my_q >> 1;
					end
				end
				ST_JEVEN: begin
					if (top_q == '0) begin
						verdict_q <= VERDICT_COMPOSITE;
						power_q   <= acc_q;
						if (bot_q != WORD_BITS'(1)) begin
							sym_q <= 2'b00;
						end else if (sign_q) begin
							sym_q <= 2'b11;
							if (acc_q == n_q - 1'b1) verdict_q <= VERDICT_PRIME;
						end else begin
							sym_q <= 2'b01;
							if (acc_q == WORD_BITS'(1)) verdict_q <= VERDICT_PRIME;
						end
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (!top_q[0]) begin
						top_q <= top_q >> 1;
						if (bot_q[2:0] == 3'd3 || bot_q[2:0] == 3'd5) sign_q <= ~sign_q;
					end else begin
						if (top_q[1:0] == 2'b11 && bot_q[1:0] == 2'b11) sign_q <= ~sign_q;
						state_q <= ST_JSWAP;
					end
				end
				ST_JSWAP: begin
					bot_q   <= top_q;
					state_q <= ST_JMOD;
				end
				ST_JMOD: begin
					if (drsp.done) begin
						top_q   <= drsp.remainder;
						state_q <= ST_JEVEN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign verdict       = verdict_q;
	assign euler_power   = power_q;
	assign jacobi_symbol = sym_q;
endmodule

@@ tb/solovay_strassen_prime_test_tb.sv @@
// Testbench for the Solovay-Strassen prime test block: directed and random candidates,
// checked against an in-bench Euler power and Jacobi symbol calculation.
// Depends on sst_pkg and solovay_strassen_prime_test.
`timescale 1ns / 1ps
module solovay_strassen_prime_test_tb;
	import sst_pkg::*;

	localparam longint unsigned CYCLE_LIMIT = 40_000_000;
	localparam int LONG_HOLD_CYCLES = 4000;

	typedef struct {
		verdict_t           verdict;
		word_t              power;
		logic signed [1:0]  symbol;
	} prime_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	word_t              candidate;
	word_t              witness_base;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         verdict;
	word_t              euler_power;
	logic signed [1:0]  jacobi_symbol;

	prime_result_t  pending_verdicts[$];
	int             error_count;
	int             sent_count;
	int             checked_count;
	int             prime_seen, composite_seen, invalid_seen;
	int             sender_idle_pct;
	int             stall_pct;
	int             stall_hold_left;
	int             hold_request;
	int             hold_served;
	longint unsigned cycle_count;

	solovay_strassen_prime_test dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.candidate(candidate), .witness_base(witness_base),
		.out_valid(out_valid), .out_stall(out_stall),
		.verdict(verdict), .euler_power(euler_power), .jacobi_symbol(jacobi_symbol)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Euler power b^((n-1)/2) mod n and Jacobi symbol (b/n), then the verdict
	function automatic prime_result_t predict_prime_test(word_t n_word, word_t b_word);
		prime_result_t   r;
		longint unsigned n, acc, sq, e, top, bottom, swap;
		bit              negative;
		n = n_word;
		if (n < 3 || n[0] == 1'b0) begin
			r.verdict = VERDICT_INVALID;
			r.power = '0;
			r.symbol = 2'sd0;
			return r;
		end
		acc = 1;
		sq = b_word % n;
		e = (n - 1) >> 1;
		while (e != 0) begin
			if (e[0])
				acc = (acc * sq) % n;
			sq = (sq * sq) % n;
			e >>= 1;
		end
		top = b_word % n;
		bottom = n;
		negative = 1'b0;
		while (top != 0) begin
			while (top[0] == 1'b0) begin
				top >>= 1;
				if (bottom[2:0] == 3 || bottom[2:0] == 5)
					negative = ~negative;
			end
			swap = top;
			top = bottom;
			bottom = swap;
			if (top[1:0] == 2'b11 && bottom[1:0] == 2'b11)
				negative = ~negative;
			top = top % bottom;
		end
		r.power = acc[31:0];
		if (bottom != 1) begin
			r.symbol = 2'sd0;
			r.verdict = VERDICT_COMPOSITE;
		end else begin
			r.symbol = negative ? -2'sd1 : 2'sd1;
			r.verdict = (acc == (negative ? n - 1 : 1)) ? VERDICT_PRIME : VERDICT_COMPOSITE;
		end
		return r;
	endfunction

	// Offer one candidate until it transfers; queue its expected result.
	// Valid stays high after the transfer so items can follow back to back.
	task automatic send_candidate(word_t n, word_t b);
		bit taken;
		while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		candidate <= n;
		witness_base <= b;
		taken = 1'b0;
		while (!taken) begin
			#1;
			taken = !in_stall;
			@(posedge clk);
			if (taken)
				pending_verdicts.push_back(predict_prime_test(n, b));
			@(negedge clk);
		end
		sent_count++;
	endtask

	// Receiver stall: random share, or a counted long hold
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_served != hold_request) begin
			out_stall <= 1'b1;
			stall_hold_left <= LONG_HOLD_CYCLES - 1;
			hold_served <= hold_request;
		end else if (stall_hold_left > 0) begin
			out_stall <= 1'b1;
			stall_hold_left <= stall_hold_left - 1;
		end else begin
			out_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
		end
	end

	// Compare each result transfer with the oldest expectation
	initial begin : result_checker
		logic               ov, os;
		logic [1:0]         v;
		word_t              p;
		logic signed [1:0]  s;
		prime_result_t      want;
		forever begin
			@(negedge clk);
			#1;
			ov = out_valid;
			os = out_stall;
			v = verdict;
			p = euler_power;
			s = jacobi_symbol;
			@(posedge clk);
			if (arst_n && ov && !os) begin
				if (pending_verdicts.size() == 0) begin
					$error("result with no candidate pending: verdict %0d", v);
					error_count++;
				end else begin
					want = pending_verdicts.pop_front();
					checked_count++;
					case (want.verdict)
						VERDICT_PRIME:     prime_seen++;
						VERDICT_COMPOSITE: composite_seen++;
						default:           invalid_seen++;
					endcase
					if (v !== want.verdict) begin
						$error("verdict: expected %0d, actual %0d", want.verdict, v);
						error_count++;
					end
					if (p !== want.power) begin
						$error("euler_power: expected %0h, actual %0h", want.power, p);
						error_count++;
					end
					if (s !== want.symbol) begin
						$error("jacobi_symbol: expected %0d, actual %0d", want.symbol, s);
						error_count++;
					end
				end
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("solovay_strassen_prime_test test failed");
			$finish;
		end
	end

	// Random candidate: mostly small widths, a few full words, some even or tiny
	function automatic word_t random_candidate();
		word_t n;
		int    bits;
		int    pick;
		pick = $urandom_range(99, 0);
		if (pick < 6)
			return word_t'($urandom_range(4, 0));
		n = $urandom;
		bits = (pick < 16) ? 32 : $urandom_range(16, 3);
		if (bits < 32)
			n = n & ((32'd1 << bits) - 32'd1);
		if (pick >= 12)
			n[0] = 1'b1;
		return n;
	endfunction

	task automatic test_invalid_candidates();
		send_candidate(32'd0, 32'd5);
		send_candidate(32'd1, 32'hFFFF_FFFF);
		send_candidate(32'd2, 32'd1);
		send_candidate(32'd4, 32'd3);
		send_candidate(32'hFFFF_FFFE, 32'hAAAA_5555);
	endtask

	task automatic test_directed_cases();
		send_candidate(32'd3, 32'd1);
		send_candidate(32'd3, 32'd2);
		send_candidate(32'd7, 32'd3);            // symbol -1 on a prime
		send_candidate(32'd13, 32'd4);
		send_candidate(32'd9, 32'd3);            // shared factor, symbol zero
		send_candidate(32'd15, 32'd0);           // base zero
		send_candidate(32'd21, 32'd21);          // base equal to candidate
		send_candidate(32'd561, 32'd2);          // Carmichael number
		send_candidate(32'd1105, 32'd5);
		send_candidate(32'd11, 32'hFFFF_FFFF);   // base far above candidate
		send_candidate(32'hFFFF_FFFB, 32'd2);    // largest 32-bit prime
		send_candidate(32'hFFFF_FFFB, 32'hFFFF_FFFA);
		send_candidate(32'hFFFF_FFFF, 32'd3);    // largest odd word, composite
		send_candidate(32'hFFFF_FFFF, 32'h5555_AAAA);
		send_candidate(32'h8000_0001, 32'h7FFF_FFFF);
	endtask

	task automatic test_random_phase(int idle, int stall, int count);
		sender_idle_pct = idle;
		stall_pct = stall;
		repeat (count)
			send_candidate(random_candidate(), $urandom);
		sender_idle_pct = 0;
		stall_pct = 0;
	endtask

	// Hold the output long enough that the block blocks its input
	task automatic test_output_backpressure();
		hold_request++;
		repeat (6)
			send_candidate(random_candidate() | 32'd1 | 32'd2, $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		candidate = '0;
		witness_base = '0;
		sent_count = 0;
		sender_idle_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_invalid_candidates();
		test_directed_cases();
		test_random_phase(0, 0, 95);
		test_random_phase(55, 0, 95);
		test_random_phase(0, 55, 95);
		test_random_phase(29, 29, 95);
		test_output_backpressure();
		in_valid <= 1'b0;

		// drain, then allow a quiet tail
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);

		$display("sent %0d candidates, checked %0d results", sent_count, checked_count);
		$display("probable prime %0d, composite %0d, invalid %0d",
			prime_seen, composite_seen, invalid_seen);
		if (error_count == 0 && pending_verdicts.size() == 0)
			$display("solovay_strassen_prime_test test passed");
		else
			$display("solovay_strassen_prime_test test failed");
		$finish;
	end
endmodule
